[rtl/mas_pkg.sv]
package mas_pkg;

   localparam int MAX_NODES      = 128;
   localparam int NODE_BITS      = $clog2(MAX_NODES);
   localparam int COUNT_BITS     = NODE_BITS + 1;
   localparam int MAT_ADDR_BITS  = 2 * NODE_BITS;
   localparam int MAT_DEPTH      = MAX_NODES * MAX_NODES;
   localparam int WEIGHT_BITS    = 32;
   localparam int TOTAL_BITS     = 39;
   localparam int OPCODE_BITS    = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [NODE_BITS-1:0]     node_type;
   typedef logic [WEIGHT_BITS-1:0]   weight_type;
   typedef logic [TOTAL_BITS-1:0]    total_type;
   typedef logic [MAT_ADDR_BITS-1:0] mat_addr_type;
   typedef logic [OPCODE_BITS-1:0]   opcode_type;

   localparam weight_type NO_EDGE = '1;

   localparam opcode_type OP_CLEAR = 2'd0;
   localparam opcode_type OP_EDGE  = 2'd1;
   localparam opcode_type OP_SOLVE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROOT_NODE  = 1'd1;

   typedef struct packed {
      node_type parent;
      logic     removed;
      logic     visited;
      node_type stack_val;
      node_type set_par;
   } node_entry_type;

   localparam int NODE_ENTRY_BITS = $bits(node_entry_type);

   typedef struct packed {
      logic         we;
      mat_addr_type waddr;
      weight_type   wdata;
      mat_addr_type raddr;
   } mat_req_type;

   typedef struct packed {
      logic           we;
      node_type       waddr;
      node_entry_type wdata;
      node_entry_type wmask;
      node_type       raddr;
   } node_req_type;

   typedef struct packed {
      logic      valid;
      total_type total;
      logic      unreachable;
   } res_type;

   function automatic mat_addr_type mat_addr(input node_type row, input node_type col);
      return {row, col};
   endfunction

   function automatic weight_type sat_sub(input weight_type a, input weight_type b);
      return (a > b) ? (a - b) : '0;
   endfunction

endpackage

[rtl/mas_ram.sv]
module mas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < WIDTH; b++) begin
            if (wr_mask[b]) begin
               mem[wr_addr][b] <= wr_data[b];
            end
         end
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/mas_engine.sv]
module mas_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mas_pkg::opcode_type                    req_opcode,
   input  mas_pkg::node_type                      req_from_node,
   input  mas_pkg::node_type                      req_to_node,
   input  mas_pkg::weight_type                    req_edge_weight,
   input  logic                                   csr_we,
   input  logic [mas_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mas_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output mas_pkg::mat_req_type                   mat_req,
   input  mas_pkg::weight_type                    mat_q,
   output mas_pkg::node_req_type                  node_req,
   input  mas_pkg::node_entry_type                node_q,
   output mas_pkg::res_type                       res,
   input  logic                                   res_ready
);

   typedef enum logic [5:0] {
      ST_IDLE, ST_CLR, ST_VCLR, ST_VPUSHR, ST_VPOP, ST_VPOPW, ST_VSCAN, ST_VSCANW,
      ST_VPUSH, ST_SINIT, ST_ITER, ST_CHI, ST_CHIW, ST_CHJ, ST_CHJW, ST_SPI,
      ST_UFI, ST_UFIW, ST_FA, ST_FAW, ST_FB, ST_FBW, ST_CYS, ST_CYW,
      ST_CW1, ST_CW1P, ST_CW1W, ST_SUB, ST_SUBW, ST_CW2, ST_CW2P, ST_CW2W,
      ST_KL, ST_KR, ST_KA, ST_KB, ST_KC, ST_KD, ST_KE,
      ST_FINAL, ST_FNW, ST_FNA, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [mas_pkg::CSR_DATA_BITS-1:0] node_count_ff;
   mas_pkg::node_type root_ff;
   mas_pkg::count_type i_ff, i_in, j_ff, j_in, k_ff, k_in, iter_ff, iter_in;
   mas_pkg::count_type g_ff, g_in, sp_ff, sp_in, seen_ff, seen_in, n_eff;
   mas_pkg::count_type sp_dec;
   mas_pkg::node_type now_ff, now_in, cyc_ff, cyc_in, cycp_ff, cycp_in;
   mas_pkg::node_type cur_ff, cur_in, a_ff, a_in, cp_ff, cp_in, jp_ff, jp_in;
   mas_pkg::weight_type best_ff, best_in, tmp_ff, tmp_in;
   mas_pkg::weight_type in_cyc_ff, in_cyc_in, in_j_ff, in_j_in;
   mas_pkg::total_type total_ff, total_in;
   mas_pkg::mat_addr_type clr_ff, clr_in;
   logic unreach_ff, unreach_in;
   mas_pkg::node_type ii, jj, kk;

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = mas_pkg::count_type'(1);
      end else if (node_count_ff > mas_pkg::CSR_DATA_BITS'(mas_pkg::MAX_NODES)) begin
         n_eff = mas_pkg::count_type'(mas_pkg::MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign ii = i_ff[mas_pkg::NODE_BITS-1:0];
   assign jj = j_ff[mas_pkg::NODE_BITS-1:0];
   assign kk = k_ff[mas_pkg::NODE_BITS-1:0];
   assign sp_dec = sp_ff - 1'b1;

   assign req_ready       = (state_ff == ST_IDLE);
   assign res.valid       = (state_ff == ST_DONE);
   assign res.total       = total_ff;
   assign res.unreachable = unreach_ff;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      iter_in   = iter_ff;
      g_in      = g_ff;
      sp_in     = sp_ff;
      seen_in   = seen_ff;
      now_in    = now_ff;
      cyc_in    = cyc_ff;
      cycp_in   = cycp_ff;
      cur_in    = cur_ff;
      a_in      = a_ff;
      cp_in     = cp_ff;
      jp_in     = jp_ff;
      best_in   = best_ff;
      tmp_in    = tmp_ff;
      in_cyc_in = in_cyc_ff;
      in_j_in   = in_j_ff;
      total_in  = total_ff;
      clr_in    = clr_ff;
      unreach_in = unreach_ff;
      mat_req   = '0;
      node_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  mas_pkg::OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  mas_pkg::OP_EDGE: begin
                     mat_req.we    = 1'b1;
                     mat_req.waddr = mas_pkg::mat_addr(req_from_node, req_to_node);
                     mat_req.wdata = req_edge_weight;
                  end
                  mas_pkg::OP_SOLVE: begin
                     if ({1'b0, root_ff} >= n_eff) begin
                        total_in   = '0;
                        unreach_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        i_in     = '0;
                        state_in = ST_VCLR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLR: begin
            mat_req.we    = 1'b1;
            mat_req.waddr = clr_ff;
            mat_req.wdata = mas_pkg::NO_EDGE;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_VCLR: begin
            node_req.we            = 1'b1;
            node_req.wmask.visited = 1'b1;
            if (i_ff == n_eff) begin
               node_req.waddr         = root_ff;
               node_req.wdata.visited = 1'b1;
               state_in               = ST_VPUSHR;
            end else begin
               node_req.waddr = ii;
               i_in           = i_ff + 1'b1;
            end
         end
         ST_VPUSHR: begin
            node_req.we              = 1'b1;
            node_req.waddr           = '0;
            node_req.wmask.stack_val = '1;
            node_req.wdata.stack_val = root_ff;
            sp_in    = mas_pkg::count_type'(1);
            seen_in  = '0;
            state_in = ST_VPOP;
         end
         ST_VPOP: begin
            if (sp_ff == '0) begin
               total_in = '0;
               if (seen_ff == n_eff) begin
                  unreach_in = 1'b0;
                  i_in       = '0;
                  state_in   = ST_SINIT;
               end else begin
                  unreach_in = 1'b1;
                  state_in   = ST_DONE;
               end
            end else begin
               sp_in          = sp_dec;
               node_req.raddr = sp_dec[mas_pkg::NODE_BITS-1:0];
               state_in       = ST_VPOPW;
            end
         end
         ST_VPOPW: begin
            now_in   = node_q.stack_val;
            seen_in  = seen_ff + 1'b1;
            i_in     = '0;
            state_in = ST_VSCAN;
         end
         ST_VSCAN: begin
            if (i_ff == n_eff) begin
               state_in = ST_VPOP;
            end else begin
               mat_req.raddr  = mas_pkg::mat_addr(now_ff, ii);
               node_req.raddr = ii;
               state_in       = ST_VSCANW;
            end
         end
         ST_VSCANW: begin
            if (!node_q.visited && mat_q != mas_pkg::NO_EDGE) begin
               node_req.we            = 1'b1;
               node_req.waddr         = ii;
               node_req.wmask.visited = 1'b1;
               node_req.wdata.visited = 1'b1;
               state_in               = ST_VPUSH;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_VSCAN;
            end
         end
         ST_VPUSH: begin
            node_req.we              = 1'b1;
            node_req.waddr           = sp_ff[mas_pkg::NODE_BITS-1:0];
            node_req.wmask.stack_val = '1;
            node_req.wdata.stack_val = ii;
            sp_in    = sp_ff + 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = ST_VSCAN;
         end
         ST_SINIT: begin
            if (i_ff == n_eff) begin
               iter_in  = '0;
               state_in = ST_ITER;
            end else begin
               node_req.we            = 1'b1;
               node_req.waddr         = ii;
               node_req.wmask.removed = 1'b1;
               i_in                   = i_ff + 1'b1;
            end
         end
         ST_ITER: begin
            i_in = '0;
            if (iter_ff == n_eff) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_CHI;
            end
         end
         ST_CHI: begin
            if (i_ff == n_eff) begin
               i_in     = '0;
               state_in = ST_SPI;
            end else if (ii == root_ff) begin
               i_in = i_ff + 1'b1;
            end else begin
               node_req.raddr = ii;
               state_in       = ST_CHIW;
            end
         end
         ST_CHIW: begin
            if (node_q.removed) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CHI;
            end else begin
               mat_req.we    = 1'b1;
               mat_req.waddr = mas_pkg::mat_addr(ii, ii);
               mat_req.wdata = mas_pkg::NO_EDGE;
               cp_in         = ii;
               best_in       = mas_pkg::NO_EDGE;
               j_in          = '0;
               state_in      = ST_CHJ;
            end
         end
         ST_CHJ: begin
            if (j_ff == n_eff) begin
               node_req.we           = 1'b1;
               node_req.waddr        = ii;
               node_req.wmask.parent = '1;
               node_req.wdata.parent = cp_ff;
               i_in                  = i_ff + 1'b1;
               state_in              = ST_CHI;
            end else begin
               node_req.raddr = jj;
               mat_req.raddr  = mas_pkg::mat_addr(jj, ii);
               state_in       = ST_CHJW;
            end
         end
         ST_CHJW: begin
            if (!node_q.removed && mat_q < best_ff) begin
               cp_in   = jj;
               best_in = mat_q;
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_CHJ;
         end
         ST_SPI: begin
            if (i_ff == n_eff) begin
               i_in     = '0;
               state_in = ST_UFI;
            end else begin
               node_req.we            = 1'b1;
               node_req.waddr         = ii;
               node_req.wmask.set_par = '1;
               node_req.wdata.set_par = ii;
               i_in                   = i_ff + 1'b1;
            end
         end
         ST_UFI: begin
            if (i_ff == n_eff) begin
               i_in     = '0;
               state_in = ST_FINAL;
            end else if (ii == root_ff) begin
               i_in = i_ff + 1'b1;
            end else begin
               node_req.raddr = ii;
               state_in       = ST_UFIW;
            end
         end
         ST_UFIW: begin
            if (node_q.removed || node_q.parent == ii) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_UFI;
            end else begin
               cp_in    = node_q.parent;
               cur_in   = ii;
               state_in = ST_FA;
            end
         end
         ST_FA: begin
            node_req.raddr = cur_ff;
            state_in       = ST_FAW;
         end
         ST_FAW: begin
            if (node_q.set_par == cur_ff) begin
               a_in     = cur_ff;
               cur_in   = cp_ff;
               state_in = ST_FB;
            end else begin
               cur_in   = node_q.set_par;
               state_in = ST_FA;
            end
         end
         ST_FB: begin
            node_req.raddr = cur_ff;
            state_in       = ST_FBW;
         end
         ST_FBW: begin
            if (node_q.set_par == cur_ff) begin
               if (a_ff == cur_ff) begin
                  cyc_in   = ii;
                  cycp_in  = cp_ff;
                  state_in = ST_CYS;
               end else begin
                  node_req.we            = 1'b1;
                  node_req.waddr         = a_ff;
                  node_req.wmask.set_par = '1;
                  node_req.wdata.set_par = cur_ff;
                  i_in                   = i_ff + 1'b1;
                  state_in               = ST_UFI;
               end
            end else begin
               cur_in   = node_q.set_par;
               state_in = ST_FB;
            end
         end
         ST_CYS: begin
            mat_req.raddr = mas_pkg::mat_addr(cycp_ff, cyc_ff);
            state_in      = ST_CYW;
         end
         ST_CYW: begin
            in_cyc_in = mat_q;
            total_in  = total_ff + mas_pkg::TOTAL_BITS'(mat_q);
            cur_in    = cycp_ff;
            g_in      = '0;
            state_in  = ST_CW1;
         end
         ST_CW1: begin
            if (cur_ff == cyc_ff || g_ff == n_eff) begin
               j_in     = '0;
               state_in = ST_SUB;
            end else begin
               node_req.raddr = cur_ff;
               state_in       = ST_CW1P;
            end
         end
         ST_CW1P: begin
            jp_in                  = node_q.parent;
            node_req.we            = 1'b1;
            node_req.waddr         = cur_ff;
            node_req.wmask.removed = 1'b1;
            node_req.wdata.removed = 1'b1;
            mat_req.raddr          = mas_pkg::mat_addr(node_q.parent, cur_ff);
            state_in               = ST_CW1W;
         end
         ST_CW1W: begin
            total_in = total_ff + mas_pkg::TOTAL_BITS'(mat_q);
            cur_in   = jp_ff;
            g_in     = g_ff + 1'b1;
            state_in = ST_CW1;
         end
         ST_SUB: begin
            if (j_ff == n_eff) begin
               cur_in   = cycp_ff;
               g_in     = '0;
               state_in = ST_CW2;
            end else begin
               node_req.raddr = jj;
               mat_req.raddr  = mas_pkg::mat_addr(jj, cyc_ff);
               state_in       = ST_SUBW;
            end
         end
         ST_SUBW: begin
            if (!node_q.removed && mat_q != mas_pkg::NO_EDGE) begin
               mat_req.we    = 1'b1;
               mat_req.waddr = mas_pkg::mat_addr(jj, cyc_ff);
               mat_req.wdata = mas_pkg::sat_sub(mat_q, in_cyc_ff);
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_SUB;
         end
         ST_CW2: begin
            if (cur_ff == cyc_ff || g_ff == n_eff) begin
               iter_in  = iter_ff + 1'b1;
               state_in = ST_ITER;
            end else begin
               node_req.raddr = cur_ff;
               state_in       = ST_CW2P;
            end
         end
         ST_CW2P: begin
            jp_in         = node_q.parent;
            mat_req.raddr = mas_pkg::mat_addr(node_q.parent, cur_ff);
            state_in      = ST_CW2W;
         end
         ST_CW2W: begin
            in_j_in  = mat_q;
            k_in     = '0;
            state_in = ST_KL;
         end
         ST_KL: begin
            if (k_ff == n_eff) begin
               cur_in   = jp_ff;
               g_in     = g_ff + 1'b1;
               state_in = ST_CW2;
            end else begin
               node_req.raddr = kk;
               state_in       = ST_KR;
            end
         end
         ST_KR: begin
            if (node_q.removed) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_KL;
            end else begin
               mat_req.raddr = mas_pkg::mat_addr(cur_ff, kk);
               state_in      = ST_KA;
            end
         end
         ST_KA: begin
            tmp_in        = mat_q;
            mat_req.raddr = mas_pkg::mat_addr(cyc_ff, kk);
            state_in      = ST_KB;
         end
         ST_KB: begin
            if (tmp_ff < mat_q) begin
               mat_req.we    = 1'b1;
               mat_req.waddr = mas_pkg::mat_addr(cyc_ff, kk);
               mat_req.wdata = tmp_ff;
            end
            state_in = ST_KC;
         end
         ST_KC: begin
            mat_req.raddr = mas_pkg::mat_addr(kk, cur_ff);
            state_in      = ST_KD;
         end
         ST_KD: begin
            if (mat_q == mas_pkg::NO_EDGE) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_KL;
            end else begin
               tmp_in        = mas_pkg::sat_sub(mat_q, in_j_ff);
               mat_req.raddr = mas_pkg::mat_addr(kk, cyc_ff);
               state_in      = ST_KE;
            end
         end
         ST_KE: begin
            if (tmp_ff < mat_q) begin
               mat_req.we    = 1'b1;
               mat_req.waddr = mas_pkg::mat_addr(kk, cyc_ff);
               mat_req.wdata = tmp_ff;
            end
            k_in     = k_ff + 1'b1;
            state_in = ST_KL;
         end
         ST_FINAL: begin
            if (i_ff == n_eff) begin
               state_in = ST_DONE;
            end else if (ii == root_ff) begin
               i_in = i_ff + 1'b1;
            end else begin
               node_req.raddr = ii;
               state_in       = ST_FNW;
            end
         end
         ST_FNW: begin
            if (node_q.removed || node_q.parent == ii) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_FINAL;
            end else begin
               mat_req.raddr = mas_pkg::mat_addr(node_q.parent, ii);
               state_in      = ST_FNA;
            end
         end
         ST_FNA: begin
            total_in = total_ff + mas_pkg::TOTAL_BITS'(mat_q);
            i_in     = i_ff + 1'b1;
            state_in = ST_FINAL;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= mas_pkg::CSR_DATA_BITS'(mas_pkg::MAX_NODES);
         root_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               mas_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata;
               mas_pkg::CSR_ROOT_NODE:  root_ff <= csr_wdata[mas_pkg::NODE_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      iter_ff   <= iter_in;
      g_ff      <= g_in;
      sp_ff     <= sp_in;
      seen_ff   <= seen_in;
      now_ff    <= now_in;
      cyc_ff    <= cyc_in;
      cycp_ff   <= cycp_in;
      cur_ff    <= cur_in;
      a_ff      <= a_in;
      cp_ff     <= cp_in;
      jp_ff     <= jp_in;
      best_ff   <= best_in;
      tmp_ff    <= tmp_in;
      in_cyc_ff <= in_cyc_in;
      in_j_ff   <= in_j_in;
      total_ff  <= total_in;
      clr_ff    <= clr_in;
      unreach_ff <= unreach_in;
   end

endmodule

[rtl/min_arborescence_solver_core.sv]
// Minimum-weight arborescence engine over a 128 x 128 weight matrix.
// The request channel takes one item per transfer: clear, add edge or solve.
// An add edge transfer writes its matrix entry and the next item can follow at once.
// A clear sweeps the whole matrix, one entry per cycle.
// A solve first runs a depth-first reachability walk from the root, then up
// to n contraction rounds; each round scans the matrix once per node and
// merges each cycle node's row and column. The speed is set by the single
// read port of the matrix memory. A solve gives one response transfer: the
// total weight, or the unreachable flag with a zero total.
// The response sits in an output register; the engine accepts the next item
// while it waits. If a second solve finishes while the receiver still stalls,
// the engine holds that result until the register frees.
// Reset returns the node count to 128 and the root to 0 and drops any
// pending response. Matrix contents are undefined until cleared. The user
// writes configuration via csr port while the engine is idle; not enforced.
module min_arborescence_solver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [6:0]                          req_from_node,
   input  logic [6:0]                          req_to_node,
   input  logic [31:0]                         req_edge_weight,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [38:0]                         rsp_total_weight,
   output logic                                rsp_unreachable,
   input  logic                                csr_we,
   input  logic [mas_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mas_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   mas_pkg::mat_req_type    mat_req;
   mas_pkg::weight_type     mat_q;
   mas_pkg::node_req_type   node_req;
   mas_pkg::node_entry_type node_q;
   logic [mas_pkg::NODE_ENTRY_BITS-1:0] node_rd;
   mas_pkg::res_type        res;
   logic                    res_ready;
   logic                    rsp_valid_ff;
   mas_pkg::total_type      rsp_total_ff;
   logic                    rsp_unreach_ff;

   mas_ram #(
      .WIDTH(mas_pkg::WEIGHT_BITS),
      .DEPTH(mas_pkg::MAT_DEPTH)
   ) u_mat_ram (
      .clock  (clock),
      .wr_en  (mat_req.we),
      .wr_addr(mat_req.waddr),
      .wr_data(mat_req.wdata),
      .wr_mask({mas_pkg::WEIGHT_BITS{1'b1}}),
      .rd_addr(mat_req.raddr),
      .rd_data(mat_q)
   );

   mas_ram #(
      .WIDTH(mas_pkg::NODE_ENTRY_BITS),
      .DEPTH(mas_pkg::MAX_NODES)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (node_req.we),
      .wr_addr(node_req.waddr),
      .wr_data(node_req.wdata),
      .wr_mask(node_req.wmask),
      .rd_addr(node_req.raddr),
      .rd_data(node_rd)
   );

   assign node_q = mas_pkg::node_entry_type'(node_rd);

   mas_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_from_node  (req_from_node),
      .req_to_node    (req_to_node),
      .req_edge_weight(req_edge_weight),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mat_req        (mat_req),
      .mat_q          (mat_q),
      .node_req       (node_req),
      .node_q         (node_q),
      .res            (res),
      .res_ready      (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid && res_ready) begin
         rsp_total_ff   <= res.total;
         rsp_unreach_ff <= res.unreachable;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_unreachable  = rsp_unreach_ff;

endmodule

[rtl/mas_checker.sv]
module mas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [1:0]                          req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [38:0]                         rsp_total_weight,
   input logic                                rsp_unreachable
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_weight))
      else $error("response dropped or changed while stalled");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unreachable |-> rsp_total_weight == '0)
      else $error("unreachable response carries a nonzero total");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == mas_pkg::OP_SOLVE |=> !req_ready)
      else $error("request taken in the cycle after a solve transfer");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == mas_pkg::OP_CLEAR |=> !req_ready)
      else $error("request taken in the cycle after a clear transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind min_arborescence_solver_core mas_checker u_mas_checker (.*);

[bench/min_arborescence_solver_core_tb.sv]
module min_arborescence_solver_core_tb;

   localparam mas_pkg::opcode_type OP_IGNORED = 2'd3;
   localparam int TOP_NODES = 128;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      logic [38:0] total;
      logic        unreachable;
   } arbor_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [6:0]  req_from_node = '0;
   logic [6:0]  req_to_node = '0;
   logic [31:0] req_edge_weight = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [38:0] rsp_total_weight;
   logic        rsp_unreachable;
   logic        csr_we = 1'b0;
   logic [mas_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mas_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   min_arborescence_solver_core u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the engine state.
   bit [31:0]   weight_mem [0:TOP_NODES*TOP_NODES-1];
   int unsigned best_parent [0:TOP_NODES-1];
   bit          merged_away [0:TOP_NODES-1];
   bit          reached [0:TOP_NODES-1];
   int unsigned walk_todo [0:TOP_NODES-1];
   int unsigned group_of [0:TOP_NODES-1];
   int unsigned nodes_in_use = 128;
   int unsigned root_sel = 0;

   arbor_result_type pending_results[$];
   int  errors = 0;
   bit  steady = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_count = 0;
   int  items_sent = 0;

   function automatic int unsigned cell_at(int unsigned r, int unsigned c);
      return r * TOP_NODES + c;
   endfunction

   function automatic int unsigned group_root(int unsigned p);
      int unsigned top, nx, guard;
      top = p;
      guard = 0;
      while (group_of[top] != top && guard < TOP_NODES) begin
         top = group_of[top];
         guard++;
      end
      guard = 0;
      while (p != top && guard < TOP_NODES) begin
         nx = group_of[p];
         group_of[p] = top;
         p = nx;
         guard++;
      end
      return top;
   endfunction

   function automatic bit spans_all(int unsigned n, int unsigned r);
      int unsigned sp, seen, now;
      sp = 0;
      seen = 0;
      for (int i = 0; i < TOP_NODES; i++) reached[i] = 0;
      reached[r] = 1;
      walk_todo[sp++] = r;
      while (sp > 0) begin
         now = walk_todo[--sp];
         seen++;
         for (int unsigned i = 0; i < n; i++) begin
            if (!reached[i] && weight_mem[cell_at(now, i)] != mas_pkg::NO_EDGE) begin
               reached[i] = 1;
               walk_todo[sp++] = i;
            end
         end
      end
      return seen == n;
   endfunction

   function automatic bit [31:0] clip_sub(bit [31:0] a, bit [31:0] b);
      return (a > b) ? a - b : 32'd0;
   endfunction

   function automatic longint unsigned min_arbor_weight(int unsigned n, int unsigned r);
      longint unsigned total;
      int unsigned cyc, a, b, j, g;
      bit found;
      bit [31:0] in_cyc, in_j, v;
      total = 0;
      for (int i = 0; i < TOP_NODES; i++) merged_away[i] = 0;
      for (int unsigned iter = 0; iter < n; iter++) begin
         cyc = 0;
         found = 0;
         for (int unsigned i = 0; i < n; i++) begin
            if (i == r || merged_away[i]) continue;
            best_parent[i] = i;
            weight_mem[cell_at(i, i)] = mas_pkg::NO_EDGE;
            for (int unsigned k = 0; k < n; k++) begin
               if (merged_away[k]) continue;
               if (weight_mem[cell_at(k, i)] < weight_mem[cell_at(best_parent[i], i)])
                  best_parent[i] = k;
            end
         end
         for (int unsigned i = 0; i < n; i++) group_of[i] = i;
         for (int unsigned i = 0; i < n; i++) begin
            if (i == r || merged_away[i] || best_parent[i] == i) continue;
            a = group_root(i);
            b = group_root(best_parent[i]);
            if (a == b) begin
               cyc = i;
               found = 1;
               break;
            end
            group_of[a] = b;
         end
         if (!found) break;
         in_cyc = weight_mem[cell_at(best_parent[cyc], cyc)];
         total += in_cyc;
         j = best_parent[cyc];
         g = 0;
         while (j != cyc && g < n) begin
            total += weight_mem[cell_at(best_parent[j], j)];
            merged_away[j] = 1;
            j = best_parent[j];
            g++;
         end
         for (int unsigned k = 0; k < n; k++) begin
            if (merged_away[k]) continue;
            if (weight_mem[cell_at(k, cyc)] != mas_pkg::NO_EDGE)
               weight_mem[cell_at(k, cyc)] = clip_sub(weight_mem[cell_at(k, cyc)], in_cyc);
         end
         j = best_parent[cyc];
         g = 0;
         while (j != cyc && g < n) begin
            in_j = weight_mem[cell_at(best_parent[j], j)];
            for (int unsigned k = 0; k < n; k++) begin
               if (merged_away[k]) continue;
               if (weight_mem[cell_at(j, k)] < weight_mem[cell_at(cyc, k)])
                  weight_mem[cell_at(cyc, k)] = weight_mem[cell_at(j, k)];
               if (weight_mem[cell_at(k, j)] != mas_pkg::NO_EDGE) begin
                  v = clip_sub(weight_mem[cell_at(k, j)], in_j);
                  if (v < weight_mem[cell_at(k, cyc)]) weight_mem[cell_at(k, cyc)] = v;
               end
            end
            j = best_parent[j];
            g++;
         end
      end
      for (int unsigned i = 0; i < n; i++) begin
         if (merged_away[i] || i == r || best_parent[i] == i) continue;
         total += weight_mem[cell_at(best_parent[i], i)];
      end
      return total;
   endfunction

   function automatic void apply_item(mas_pkg::opcode_type op, int unsigned f,
                                      int unsigned t, bit [31:0] w);
      arbor_result_type res;
      int unsigned n;
      case (op)
         mas_pkg::OP_CLEAR: begin
            for (int e = 0; e < TOP_NODES * TOP_NODES; e++) weight_mem[e] = mas_pkg::NO_EDGE;
         end
         mas_pkg::OP_EDGE: begin
            weight_mem[cell_at(f, t)] = w;
         end
         mas_pkg::OP_SOLVE: begin
            n = nodes_in_use;
            if (n == 0) n = 1;
            if (n > TOP_NODES) n = TOP_NODES;
            if (root_sel >= n || !spans_all(n, root_sel)) begin
               res.total = '0;
               res.unreachable = 1'b1;
            end else begin
               res.total = 39'(min_arbor_weight(n, root_sel));
               res.unreachable = 1'b0;
            end
            pending_results.push_back(res);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(mas_pkg::opcode_type op, int unsigned f, int unsigned t,
                            bit [31:0] w);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_from_node <= f[6:0];
      req_to_node <= t[6:0];
      req_edge_weight <= w;
      do @(posedge clock); while (!req_ready);
      apply_item(op, f, t, w);
      items_sent++;
      if (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [mas_pkg::CSR_INDEX_BITS-1:0] idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mas_pkg::CSR_NODE_COUNT) nodes_in_use = value & 8'hFF;
      else root_sel = value & 7'h7F;
   endtask

   task automatic set_graph_size(int unsigned n, int unsigned r);
      write_csr(mas_pkg::CSR_NODE_COUNT, n);
      write_csr(mas_pkg::CSR_ROOT_NODE, r);
   endtask

   function automatic bit [31:0] pick_weight();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45) return $urandom_range(0, 15);
      if (sel < 95) return $urandom();
      if (sel < 98) return 32'hFFFF_FFFE;
      return mas_pkg::NO_EDGE;
   endfunction

   always @(posedge clock) begin
      if (hold_req && hold_count < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (!hold_req) hold_count <= 0;
         rsp_ready <= steady || ($urandom_range(99) >= 29);
      end
   end

   always @(posedge clock) begin
      arbor_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer total=%0d unreachable=%0b",
                     $time, rsp_total_weight, rsp_unreachable);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_total_weight !== exp_res.total) begin
               errors++;
               $display("%0t: total_weight expected %0d actual %0d",
                        $time, exp_res.total, rsp_total_weight);
            end
            if (rsp_unreachable !== exp_res.unreachable) begin
               errors++;
               $display("%0t: unreachable expected %0b actual %0b",
                        $time, exp_res.unreachable, rsp_unreachable);
            end
         end
      end
   end

   task automatic test_small_graph();
      set_graph_size(4, 0);
      send_item(mas_pkg::OP_CLEAR, 0, 0, 0);
      send_item(mas_pkg::OP_EDGE, 0, 1, 5);
      send_item(mas_pkg::OP_EDGE, 1, 2, 0);
      send_item(mas_pkg::OP_EDGE, 2, 1, 1);
      send_item(mas_pkg::OP_EDGE, 0, 2, 32'hFFFF_FFFE);
      send_item(mas_pkg::OP_EDGE, 2, 3, 7);
      send_item(mas_pkg::OP_EDGE, 3, 3, 0);
      send_item(mas_pkg::OP_EDGE, 1, 0, 0);
      send_item(mas_pkg::OP_EDGE, 3, 2, mas_pkg::NO_EDGE);
      send_item(OP_IGNORED, 127, 127, 32'hFFFF_FFFF);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      send_item(mas_pkg::OP_EDGE, 127, 127, 32'hAAAA_5555);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
   endtask

   task automatic test_size_limits();
      set_graph_size(4, 5);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
      set_graph_size(0, 0);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
      set_graph_size(1, 0);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
      set_graph_size(128, 127);
      send_item(mas_pkg::OP_CLEAR, 0, 0, 0);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
      set_graph_size(200, 0);
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      drain_results();
   endtask

   task automatic test_backpressure();
      set_graph_size(3, 0);
      send_item(mas_pkg::OP_EDGE, 0, 1, 3);
      send_item(mas_pkg::OP_EDGE, 1, 2, 4);
      steady = 1'b1;
      hold_req = 1'b1;
      repeat (6) send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
      steady = 1'b0;
      drain_results();
      hold_req = 1'b0;
   endtask

   task automatic send_spanning_set(int unsigned n, int unsigned r);
      int unsigned order[$];
      int unsigned extra;
      for (int unsigned i = 0; i < n; i++) if (i != r) order.push_back(i);
      order.shuffle();
      order.push_front(r);
      for (int i = 1; i < order.size(); i++)
         send_item(mas_pkg::OP_EDGE, order[$urandom_range(0, i - 1)], order[i], pick_weight());
      extra = $urandom_range(0, n + 2);
      repeat (extra)
         send_item(mas_pkg::OP_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   pick_weight());
      send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
   endtask

   task automatic send_noise();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50)
         send_item(mas_pkg::OP_EDGE, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom());
      else if (sel < 70)
         send_item(OP_IGNORED, $urandom_range(0, 127), $urandom_range(0, 127), $urandom());
      else if (sel < 80)
         send_item(mas_pkg::OP_EDGE, $urandom_range(0, 127), $urandom_range(0, 127),
                   mas_pkg::NO_EDGE);
      else
         send_item(mas_pkg::OP_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom());
   endtask

   task automatic test_random_graphs();
      int unsigned n, r, phase_start, start;
      mas_pkg::opcode_type last_op;
      start = items_sent;
      while (items_sent - start < 530) begin
         phase_start = items_sent;
         n = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(2, 8);
         r = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, n - 1);
         set_graph_size(n, r);
         if ($urandom_range(7) == 0) send_item(mas_pkg::OP_CLEAR, 0, 0, 0);
         steady = (items_sent - start > 200 && items_sent - start < 280);
         while (items_sent - phase_start < 40) begin
            if ($urandom_range(99) < 75 && r < n) begin
               send_spanning_set(n, r);
               last_op = mas_pkg::OP_SOLVE;
            end else begin
               send_noise();
               last_op = req_opcode;
            end
         end
         if (last_op != mas_pkg::OP_SOLVE) send_item(mas_pkg::OP_SOLVE, 0, 0, 0);
         steady = 1'b0;
         drain_results();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_graph();
      test_size_limits();
      test_backpressure();
      test_random_graphs();
      drain_results();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("FAIL");
      $finish;
   end

endmodule
